// ===== hdl/pnsa_pkg.sv =====
`timescale 1ns / 1ps
package pnsa_pkg;

    // Output coordinate width and coefficient fraction width
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DEST_W    = 15;
    localparam int COEF_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int RECT_W    = 16;

    // coef (signed 32) times zero-extended dest (16) and the three-term sum
    localparam int PROD_W = COEF_W + DEST_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W;
    localparam int REM_W  = MAG_W + COORD_BITS;

    // Compare width for the rectangle test
    localparam int CMP_W = ((COORD_BITS > RECT_W) ? COORD_BITS : RECT_W) + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M00_M01 = 3'd0,
        REG_M02_M10 = 3'd1,
        REG_M11_M12 = 3'd2,
        REG_M20_M21 = 3'd3,
        REG_M22     = 3'd4,
        REG_ORIGIN  = 3'd5,
        REG_EXTENT  = 3'd6
    } t_cfg_idx;

    // Per-request data that rides alongside the divider
    typedef struct packed {
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
        logic              neg_x;
        logic              neg_y;
        logic              zero_den;
    } t_sb;

endpackage

// ===== hdl/pnsa_in_if.sv =====
`timescale 1ns / 1ps
interface pnsa_in_if import pnsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;

    modport source (output valid, dest_x, dest_y, input ready);
    modport sink   (input valid, dest_x, dest_y, output ready);
endinterface

// ===== hdl/pnsa_out_if.sv =====
`timescale 1ns / 1ps
interface pnsa_out_if import pnsa_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [DEST_W-1:0]            out_dest_x;
    logic [DEST_W-1:0]            out_dest_y;
    logic signed [COORD_BITS-1:0] source_x;
    logic signed [COORD_BITS-1:0] source_y;
    logic                         inside_res;

    modport source (output valid, out_dest_x, out_dest_y, source_x, source_y, inside_res,
                    input ready);
    modport sink   (input valid, out_dest_x, out_dest_y, source_x, source_y, inside_res,
                    output ready);
endinterface

// ===== hdl/pnsa_div.sv =====
`timescale 1ns / 1ps
module pnsa_div import pnsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [MAG_W-1:0]      i_num,
    input  logic [MAG_W-1:0]      i_den,
    output logic [COORD_BITS-1:0] o_quo,
    output logic                  o_ovf
);

    logic [REM_W-1:0]      r_rem [0:COORD_BITS-1];
    logic [MAG_W-1:0]      r_den [0:COORD_BITS-1];
    logic [COORD_BITS-1:0] r_quo [0:COORD_BITS];
    logic                  r_ovf [0:COORD_BITS];

    // Load: flag quotients that cannot fit in COORD_BITS magnitude bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= REM_W'(i_num) >= {i_den, {COORD_BITS{1'b0}}};
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar k = 1; k <= COORD_BITS; k++) begin : g_step
        localparam int SH = COORD_BITS - k;
        logic [REM_W-1:0]      n_dsh;
        logic                  n_ge;
        logic [REM_W-1:0]      n_rem;
        logic [COORD_BITS-1:0] n_quo;

        always_comb begin
            n_dsh = REM_W'(r_den[k-1]) << SH;
            n_ge  = r_rem[k-1] >= n_dsh;
            n_rem = n_ge ? (r_rem[k-1] - n_dsh) : r_rem[k-1];
            n_quo = r_quo[k-1] | (COORD_BITS'(n_ge) << SH);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= n_quo;
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < COORD_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quo = r_quo[COORD_BITS];
    assign o_ovf = r_ovf[COORD_BITS];

endmodule

// ===== hdl/perspective_nearest_source_address_core.sv =====
`timescale 1ns / 1ps
// Maps each destination pixel (dest_x, dest_y) through an inverse 3x3 homography
// with signed Q16.16 coefficients and returns the truncated source coordinate and
// an inside flag for the source rectangle. One request is taken every clock while
// the output is not stalled; a result passes stages A, B and C, then the divider,
// which resolves one quotient bit per stage for x and y side by side, and then the
// output register. A stalled output holds the whole pipeline. Write the registers
// only while no request is in flight.
module perspective_nearest_source_address_core import pnsa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pnsa_in_if.sink              i_req,
    pnsa_out_if.source           o_res
);

    localparam int SB_N = COORD_BITS + 1;

    // Configuration
    logic [CFG_W-1:0]  r_m00_m01, r_m02_m10, r_m11_m12, r_m20_m21;
    logic [COEF_W-1:0] r_m22, r_origin, r_extent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00_m01 <= CFG_W'(1) << (FRAC_BITS + COEF_W);
            r_m02_m10 <= '0;
            r_m11_m12 <= CFG_W'(1) << (FRAC_BITS + COEF_W);
            r_m20_m21 <= '0;
            r_m22     <= COEF_W'(1) << FRAC_BITS;
            r_origin  <= '0;
            r_extent  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_M00_M01: r_m00_m01 <= i_cfg_data;
                REG_M02_M10: r_m02_m10 <= i_cfg_data;
                REG_M11_M12: r_m11_m12 <= i_cfg_data;
                REG_M20_M21: r_m20_m21 <= i_cfg_data;
                REG_M22:     r_m22     <= i_cfg_data[COEF_W-1:0];
                REG_ORIGIN:  r_origin  <= i_cfg_data[COEF_W-1:0];
                REG_EXTENT:  r_extent  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] w_m00, w_m01, w_m02, w_m10, w_m11, w_m12, w_m20, w_m21, w_m22;
    assign w_m00 = r_m00_m01[CFG_W-1:COEF_W];
    assign w_m01 = r_m00_m01[COEF_W-1:0];
    assign w_m02 = r_m02_m10[CFG_W-1:COEF_W];
    assign w_m10 = r_m02_m10[COEF_W-1:0];
    assign w_m11 = r_m11_m12[CFG_W-1:COEF_W];
    assign w_m12 = r_m11_m12[COEF_W-1:0];
    assign w_m20 = r_m20_m21[CFG_W-1:COEF_W];
    assign w_m21 = r_m20_m21[COEF_W-1:0];
    assign w_m22 = r_m22;

    // Global advance: move when the output slot is empty or being taken
    logic w_en;
    logic r_out_vld;
    assign w_en        = !r_out_vld || o_res.ready;
    assign i_req.ready = w_en;

    // Stage A: capture request
    logic              r_va;
    logic [DEST_W-1:0] r_ax, r_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_va <= 1'b0;
        else if (w_en) r_va <= i_req.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax <= i_req.dest_x;
            r_ay <= i_req.dest_y;
        end
    end

    // Stage B: six products
    logic signed [DEST_W:0]   w_sx, w_sy;
    logic                     r_vb;
    logic [DEST_W-1:0]        r_bx, r_by;
    logic signed [PROD_W-1:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    assign w_sx = signed'({1'b0, r_ax});
    assign w_sy = signed'({1'b0, r_ay});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vb <= 1'b0;
        else if (w_en) r_vb <= r_va;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bx  <= r_ax;
            r_by  <= r_ay;
            r_p00 <= w_m00 * w_sx;
            r_p01 <= w_m01 * w_sy;
            r_p10 <= w_m10 * w_sx;
            r_p11 <= w_m11 * w_sy;
            r_p20 <= w_m20 * w_sx;
            r_p21 <= w_m21 * w_sy;
        end
    end

    // Stage C: numerators and denominator
    logic                    r_vc;
    logic [DEST_W-1:0]       r_cx, r_cy;
    logic signed [SUM_W-1:0] r_nx, r_ny, r_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vc <= 1'b0;
        else if (w_en) r_vc <= r_vb;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx <= r_bx;
            r_cy <= r_by;
            r_nx <= SUM_W'(r_p00) + SUM_W'(r_p01) + SUM_W'(w_m02);
            r_ny <= SUM_W'(r_p10) + SUM_W'(r_p11) + SUM_W'(w_m12);
            r_d  <= SUM_W'(r_p20) + SUM_W'(r_p21) + SUM_W'(w_m22);
        end
    end

    // Magnitudes and signs into the divider
    logic [MAG_W-1:0] w_anx, w_any, w_ad;
    assign w_anx = r_nx[SUM_W-1] ? MAG_W'(-r_nx) : MAG_W'(r_nx);
    assign w_any = r_ny[SUM_W-1] ? MAG_W'(-r_ny) : MAG_W'(r_ny);
    assign w_ad  = r_d[SUM_W-1]  ? MAG_W'(-r_d)  : MAG_W'(r_d);

    logic [COORD_BITS-1:0] w_qx, w_qy;
    logic                  w_ovx, w_ovy;

    pnsa_div u_div_x (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_anx), .i_den (w_ad),
        .o_quo (w_qx), .o_ovf (w_ovx)
    );
    pnsa_div u_div_y (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_any), .i_den (w_ad),
        .o_quo (w_qy), .o_ovf (w_ovy)
    );

    // Sideband line matching the divider depth
    logic r_vsb [0:SB_N-1];
    t_sb  r_sb  [0:SB_N-1];
    t_sb  n_sb0;
    always_comb begin
        n_sb0.dest_x   = r_cx;
        n_sb0.dest_y   = r_cy;
        n_sb0.neg_x    = r_nx[SUM_W-1] ^ r_d[SUM_W-1];
        n_sb0.neg_y    = r_ny[SUM_W-1] ^ r_d[SUM_W-1];
        n_sb0.zero_den = (r_d == '0);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SB_N; i++) r_vsb[i] <= 1'b0;
        end else if (w_en) begin
            r_vsb[0] <= r_vc;
            for (int i = 1; i < SB_N; i++) r_vsb[i] <= r_vsb[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= n_sb0;
            for (int i = 1; i < SB_N; i++) r_sb[i] <= r_sb[i-1];
        end
    end

    // Final: sign, saturate, rectangle test
    t_sb                          w_last;
    logic                         n_satx, n_saty;
    logic [COORD_BITS-1:0]        n_fx, n_fy;
    logic signed [COORD_BITS-1:0] n_srcx, n_srcy;
    logic signed [CMP_W-1:0]      n_cx, n_cy, n_left, n_top, n_right, n_bot;
    logic                         n_inside;
    localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    assign w_last = r_sb[SB_N-1];

    always_comb begin
        n_satx = w_ovx || (w_last.neg_x ? (w_qx[COORD_BITS-1] && (|w_qx[COORD_BITS-2:0]))
                                        : w_qx[COORD_BITS-1]);
        n_saty = w_ovy || (w_last.neg_y ? (w_qy[COORD_BITS-1] && (|w_qy[COORD_BITS-2:0]))
                                        : w_qy[COORD_BITS-1]);
        n_fx = w_last.neg_x ? (n_satx ? MINV : -w_qx) : (n_satx ? MAXV : w_qx);
        n_fy = w_last.neg_y ? (n_saty ? MINV : -w_qy) : (n_saty ? MAXV : w_qy);
        if (w_last.zero_den) begin
            n_srcx = '0;
            n_srcy = '0;
        end else begin
            n_srcx = n_fx;
            n_srcy = n_fy;
        end
        n_cx    = CMP_W'(n_srcx);
        n_cy    = CMP_W'(n_srcy);
        n_left  = CMP_W'({1'b0, r_origin[2*RECT_W-1:RECT_W]});
        n_top   = CMP_W'({1'b0, r_origin[RECT_W-1:0]});
        n_right = n_left + CMP_W'({1'b0, r_extent[2*RECT_W-1:RECT_W]});
        n_bot   = n_top + CMP_W'({1'b0, r_extent[RECT_W-1:0]});
        n_inside = !w_last.zero_den && !n_satx && !n_saty
                   && (n_cx >= n_left) && (n_cx < n_right)
                   && (n_cy >= n_top) && (n_cy < n_bot);
    end

    logic [DEST_W-1:0]            r_ox, r_oy;
    logic signed [COORD_BITS-1:0] r_srcx, r_srcy;
    logic                         r_inside;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_out_vld <= 1'b0;
        else if (w_en) r_out_vld <= r_vsb[SB_N-1];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox     <= w_last.dest_x;
            r_oy     <= w_last.dest_y;
            r_srcx   <= n_srcx;
            r_srcy   <= n_srcy;
            r_inside <= n_inside;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.out_dest_x = r_ox;
    assign o_res.out_dest_y = r_oy;
    assign o_res.source_x   = r_srcx;
    assign o_res.source_y   = r_srcy;
    assign o_res.inside_res = r_inside;

    // A point inside the rectangle never has a negative coordinate
    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_inside) |-> (!r_srcx[COORD_BITS-1] && !r_srcy[COORD_BITS-1]))
        else $error("inside flag with negative source coordinate");

    // An empty rectangle never reports inside
    a_empty_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_extent[2*RECT_W-1:RECT_W] == '0 || r_extent[RECT_W-1:0] == '0))
        |-> !r_inside)
        else $error("inside flag with empty source rectangle");

    // Zero denominator gives a zero coordinate at the output
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vsb[SB_N-1] && w_last.zero_den)
        |=> (r_srcx == '0 && r_srcy == '0 && !r_inside))
        else $error("zero denominator not forced to zero");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import pnsa_pkg::*;

    localparam int LATENCY   = COORD_BITS + 5;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [DEST_W-1:0]            dest_x;
        logic [DEST_W-1:0]            dest_y;
        logic signed [COORD_BITS-1:0] source_x;
        logic signed [COORD_BITS-1:0] source_y;
        logic                         inside_res;
    } t_addr;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    pnsa_in_if  req_if ();
    pnsa_out_if res_if ();

    perspective_nearest_source_address_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // Shadow copy of the homography and rectangle registers
    logic [63:0] hom_regs [0:3];
    logic [31:0] m22_reg;
    logic [31:0] origin_reg;
    logic [31:0] extent_reg;

    t_addr expected_addrs [$];
    int    mismatches;
    int    cycles;
    int    send_idle_pct;
    int    recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Saturate a quotient to the signed coordinate range
    function automatic longint clamp_coord(input longint q, inout bit ok);
        longint maxv;
        longint minv;
        maxv = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        minv = -(longint'(1) <<< (COORD_BITS - 1));
        if (q > maxv) begin
            ok = 1'b0;
            return maxv;
        end
        if (q < minv) begin
            ok = 1'b0;
            return minv;
        end
        return q;
    endfunction

    function automatic longint coef(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // Map one destination pixel to its source address
    function automatic t_addr map_source(input logic [DEST_W-1:0] dx,
                                         input logic [DEST_W-1:0] dy);
        t_addr  r;
        longint x;
        longint y;
        longint nx;
        longint ny;
        longint den;
        longint sx;
        longint sy;
        longint left;
        longint top;
        bit     ok;
        x   = longint'(dx);
        y   = longint'(dy);
        nx  = coef(hom_regs[0][63:32]) * x + coef(hom_regs[0][31:0]) * y
            + coef(hom_regs[1][63:32]);
        ny  = coef(hom_regs[1][31:0]) * x + coef(hom_regs[2][63:32]) * y
            + coef(hom_regs[2][31:0]);
        den = coef(hom_regs[3][63:32]) * x + coef(hom_regs[3][31:0]) * y + coef(m22_reg);
        sx  = 0;
        sy  = 0;
        ok  = 1'b0;
        if (den != 0) begin
            ok = 1'b1;
            sx = clamp_coord(nx / den, ok);
            sy = clamp_coord(ny / den, ok);
            if (ok) begin
                left = longint'(origin_reg[31:16]);
                top  = longint'(origin_reg[15:0]);
                ok = sx >= left && sx < left + longint'(extent_reg[31:16])
                  && sy >= top && sy < top + longint'(extent_reg[15:0]);
            end
        end
        r.dest_x     = dx;
        r.dest_y     = dy;
        r.source_x   = sx[COORD_BITS-1:0];
        r.source_y   = sy[COORD_BITS-1:0];
        r.inside_res = ok;
        return r;
    endfunction

    // Write one register, then drop the write enable and update the shadow copy
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_M00_M01: hom_regs[0] = value;
            REG_M02_M10: hom_regs[1] = value;
            REG_M11_M12: hom_regs[2] = value;
            REG_M20_M21: hom_regs[3] = value;
            REG_M22:     m22_reg = value[31:0];
            REG_ORIGIN:  origin_reg = value[31:0];
            REG_EXTENT:  extent_reg = value[31:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] pack_pair(input int hi, input int lo);
        return {hi[31:0], lo[31:0]};
    endfunction

    task automatic load_matrix(input int m00, input int m01, input int m02,
                               input int m10, input int m11, input int m12,
                               input int m20, input int m21, input int m22);
        write_reg(REG_M00_M01, pack_pair(m00, m01));
        write_reg(REG_M02_M10, pack_pair(m02, m10));
        write_reg(REG_M11_M12, pack_pair(m11, m12));
        write_reg(REG_M20_M21, pack_pair(m20, m21));
        write_reg(REG_M22, {32'd0, m22[31:0]});
    endtask

    task automatic load_rect(input logic [15:0] left, input logic [15:0] top,
                             input logic [15:0] w, input logic [15:0] h);
        write_reg(REG_ORIGIN, {32'd0, left, top});
        write_reg(REG_EXTENT, {32'd0, w, h});
    endtask

    // Send one request, with a random gap before it
    task automatic send_pixel(input logic [DEST_W-1:0] dx, input logic [DEST_W-1:0] dy);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.dest_x <= dx;
        req_if.dest_y <= dy;
        expected_addrs.push_back(map_source(dx, dy));
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let the pipeline empty before touching registers
    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [DEST_W-1:0] rand_dest();
        case ($urandom_range(3))
            0: return DEST_W'($urandom_range(15));
            1: return {DEST_W{1'b1}} - DEST_W'($urandom_range(15));
            default: return DEST_W'($urandom);
        endcase
    endfunction

    function automatic int rand_coef();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return int'($urandom_range(131072)) - 65536;
            3: return 0;
            default: return int'($urandom);
        endcase
    endfunction

    // Identity map at reset: rectangle is empty, so nothing is inside
    task automatic test_reset_map();
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(15'h5555, 15'h2aaa);
        drain();
    endtask

    // Field extremes, scaling, zero denominator, saturation, empty rectangle
    task automatic test_directed();
        load_rect(16'd0, 16'd0, 16'hffff, 16'hffff);
        send_pixel('0, '0);
        send_pixel('1, '0);
        send_pixel('0, '1);
        send_pixel(15'h2aaa, 15'h5555);
        drain();
        // half scale with offset, rectangle near the low end of the range
        load_matrix(32768, 0, 100 << 16, 0, 32768, -(5 << 16), 0, 0, 65536);
        load_rect(16'd10, 16'd0, 16'd200, 16'd100);
        send_pixel(15'd0, 15'd0);
        send_pixel(15'd219, 15'd209);
        send_pixel(15'd220, 15'd210);
        send_pixel(15'd1000, 15'd7);
        drain();
        // denominator vanishes on one line
        load_matrix(65536, 0, 0, 0, 65536, 0, -65536, 0, 100 << 16);
        load_rect(16'd0, 16'd0, 16'd0, 16'd50);
        send_pixel(15'd100, 15'd3);
        send_pixel(15'd99, 15'd3);
        send_pixel(15'd101, 15'd3);
        drain();
        // huge coefficients saturate both ways
        load_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 1);
        load_rect(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_pixel('1, '1);
        send_pixel('0, '0);
        drain();
    endtask

    // Random matrices, rectangles and pixels
    task automatic test_random(input int phases, input int per_phase);
        logic [15:0] w;
        logic [15:0] h;
        for (int p = 0; p < phases; p++) begin
            if ($urandom_range(3) == 0) begin
                load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef());
            end else begin
                // near affine maps give results mostly in range
                load_matrix(int'($urandom_range(131072)) - 65536,
                            int'($urandom_range(131072)) - 65536,
                            int'($urandom),
                            int'($urandom_range(131072)) - 65536,
                            int'($urandom_range(131072)) - 65536,
                            int'($urandom),
                            int'($urandom_range(8)) - 4,
                            int'($urandom_range(8)) - 4,
                            int'($urandom_range(1 << 18)) - (1 << 17));
            end
            w = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
            h = ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom);
            load_rect(16'($urandom_range(65535)), 16'($urandom), w, h);
            for (int i = 0; i < per_phase; i++) send_pixel(rand_dest(), rand_dest());
            drain();
        end
    endtask

    // Receiver stall and result check
    always @(posedge i_clk) begin
        t_addr act;
        t_addr exp_addr;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                act = {res_if.out_dest_x, res_if.out_dest_y, res_if.source_x,
                       res_if.source_y, res_if.inside_res};
                if (expected_addrs.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", act);
                end else begin
                    exp_addr = expected_addrs.pop_front();
                    if (act !== exp_addr) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_addr, act);
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("** perspective_nearest_source_address_core: FAILED **");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 35;
        recv_idle_pct = 46;
        hom_regs[0]   = 64'd1 << (FRAC_BITS + 32);
        hom_regs[1]   = '0;
        hom_regs[2]   = 64'd1 << (FRAC_BITS + 32);
        hom_regs[3]   = '0;
        m22_reg       = 32'd1 << FRAC_BITS;
        origin_reg    = '0;
        extent_reg    = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        req_if.valid  = 1'b0;
        req_if.dest_x = '0;
        req_if.dest_y = '0;
        res_if.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_map();
        test_directed();
        test_random(8, 70);
        send_idle_pct = 46;
        recv_idle_pct = 35;
        test_random(8, 70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(8, 70);
        end_burst();
        drain();

        if (mismatches == 0 && expected_addrs.size() == 0) begin
            $display("** perspective_nearest_source_address_core: PASSED **");
        end else begin
            $display("** perspective_nearest_source_address_core: FAILED **");
        end
        $finish;
    end
endmodule
